/* hw/rtl/scpf_pkg.sv */
// Shared types and constants for the servo command packet framer.
package scpf_pkg;

	localparam int BYTE_W              = 8;
	localparam int PAYLOAD_W           = 32;
	localparam int PAYLOAD_FIELD_BYTES = PAYLOAD_W / BYTE_W;
	localparam int COUNT_W             = 3;
	localparam int FIXED_BYTES         = 7;

	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hFA;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hAF;

	// one slot of the shift row
	typedef struct packed {
		logic              vld;
		logic              lst;
		logic [BYTE_W-1:0] data;
	} slot_t;

endpackage

/* hw/rtl/scpf_cmd_if.sv */
// Command channel: one servo command per beat.
interface scpf_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [scpf_pkg::BYTE_W-1:0]        servo_id;
	logic [scpf_pkg::BYTE_W-1:0]        flags;
	logic [scpf_pkg::BYTE_W-1:0]        address;
	logic [scpf_pkg::BYTE_W-1:0]        item_length;
	logic [scpf_pkg::BYTE_W-1:0]        item_count;
	logic [scpf_pkg::PAYLOAD_W-1:0]     payload;
	logic [scpf_pkg::COUNT_W-1:0]       payload_bytes;

	modport source (
		output valid, servo_id, flags, address, item_length, item_count, payload,
			payload_bytes,
		input  ready
	);
	modport sink (
		input  valid, servo_id, flags, address, item_length, item_count, payload,
			payload_bytes,
		output ready
	);
endinterface

/* hw/rtl/scpf_byte_if.sv */
// Byte channel: one packet byte per beat.
interface scpf_byte_if;
	logic                        valid;
	logic                        ready;
	logic [scpf_pkg::BYTE_W-1:0] packet_byte;
	logic                        last_byte;

	modport source (
		output valid, packet_byte, last_byte,
		input  ready
	);
	modport sink (
		input  valid, packet_byte, last_byte,
		output ready
	);
endinterface

/* hw/rtl/servo_command_packet_framer_unit.sv */
// Servo command packet framer: command in, short-packet byte stream out.
//
// Each accepted command becomes one packet of 8 to 12 bytes: 0xFA, 0xAF, id,
// flags, address, length, count, the payload bytes low byte first (payload_bytes
// of them, clamped to MAX_PAYLOAD_BYTES and to the four bytes of the payload
// field), then the XOR of every byte from id through the last payload byte,
// marked with last_byte. Bytes leave one per beat. A command is loaded in
// parallel into a row of byte cells which then shift one place per cycle
// towards the output while the sink is ready or cell 0 is empty; cell 0 is
// the output register. A new command is taken in the cycle the final byte of
// the previous packet is handed over, so with an always-ready sink packets
// follow gaplessly. The rate is set by the single byte-wide output port.
// First byte appears in the cycle after the command beat. No state survives
// between commands.
module servo_command_packet_framer_unit #(
	parameter int MAX_PAYLOAD_BYTES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	scpf_cmd_if.sink     cmd,
	scpf_byte_if.source  pkt
);

	// payload slots actually usable
	localparam int PL_LIM = (MAX_PAYLOAD_BYTES < scpf_pkg::PAYLOAD_FIELD_BYTES) ?
		MAX_PAYLOAD_BYTES : scpf_pkg::PAYLOAD_FIELD_BYTES;
	localparam int DEPTH  = scpf_pkg::FIXED_BYTES + PL_LIM + 1;

	scpf_pkg::slot_t row   [DEPTH];
	scpf_pkg::slot_t cells [DEPTH];
	logic [DEPTH-1:0] vld;
	logic             load;
	logic             shift;

	scpf_frame_build #(
		.PL_LIM(PL_LIM)
	) u_build (
		.servo_id      (cmd.servo_id),
		.flags         (cmd.flags),
		.address       (cmd.address),
		.item_length   (cmd.item_length),
		.item_count    (cmd.item_count),
		.payload       (cmd.payload),
		.payload_bytes (cmd.payload_bytes),
		.row           (row)
	);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vld[i] = cells[i].vld;
		end
	end

	// Row advances whenever the head byte leaves or the head is empty.
	assign shift = pkt.ready | ~vld[0];
	// Take a new command once nothing but the head byte remains and it is leaving or absent.
	assign cmd.ready = ~(|vld[DEPTH-1:1]) & shift;
	assign load      = cmd.valid & cmd.ready;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		scpf_pkg::slot_t nxt;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cells[i+1];
		end

		scpf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load),
			.shift    (shift),
			.load_val (row[i]),
			.nxt      (nxt),
			.cur      (cells[i])
		);
	end

	assign pkt.valid       = cells[0].vld;
	assign pkt.packet_byte = cells[0].data;
	assign pkt.last_byte   = cells[0].lst;

endmodule

/* hw/rtl/scpf_frame_build.sv */
// Lays out one command as a row of packet slots, checksum included.
module scpf_frame_build #(
	parameter int PL_LIM = 4
) (
	input  logic [scpf_pkg::BYTE_W-1:0]    servo_id,
	input  logic [scpf_pkg::BYTE_W-1:0]    flags,
	input  logic [scpf_pkg::BYTE_W-1:0]    address,
	input  logic [scpf_pkg::BYTE_W-1:0]    item_length,
	input  logic [scpf_pkg::BYTE_W-1:0]    item_count,
	input  logic [scpf_pkg::PAYLOAD_W-1:0] payload,
	input  logic [scpf_pkg::COUNT_W-1:0]   payload_bytes,
	output scpf_pkg::slot_t                row [scpf_pkg::FIXED_BYTES + PL_LIM + 1]
);

	localparam int DEPTH = scpf_pkg::FIXED_BYTES + PL_LIM + 1;

	logic [scpf_pkg::COUNT_W-1:0] cnt;
	logic [scpf_pkg::BYTE_W-1:0]  pl_byte [PL_LIM];
	logic [scpf_pkg::BYTE_W-1:0]  csum;

	// clamp to what the row can hold
	assign cnt = (payload_bytes > scpf_pkg::COUNT_W'(PL_LIM)) ?
		scpf_pkg::COUNT_W'(PL_LIM) : payload_bytes;

	always_comb begin
		for (int j = 0; j < PL_LIM; j++) begin
			pl_byte[j] = payload[j*scpf_pkg::BYTE_W +: scpf_pkg::BYTE_W];
		end
	end

	always_comb begin
		csum = servo_id ^ flags ^ address ^ item_length ^ item_count;
		for (int j = 0; j < PL_LIM; j++) begin
			if (scpf_pkg::COUNT_W'(j) < cnt) begin
				csum = csum ^ pl_byte[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			row[i] = '0;
		end
		row[0] = '{vld: 1'b1, lst: 1'b0, data: scpf_pkg::HDR_FIRST};
		row[1] = '{vld: 1'b1, lst: 1'b0, data: scpf_pkg::HDR_SECOND};
		row[2] = '{vld: 1'b1, lst: 1'b0, data: servo_id};
		row[3] = '{vld: 1'b1, lst: 1'b0, data: flags};
		row[4] = '{vld: 1'b1, lst: 1'b0, data: address};
		row[5] = '{vld: 1'b1, lst: 1'b0, data: item_length};
		row[6] = '{vld: 1'b1, lst: 1'b0, data: item_count};
		for (int j = 0; j <= PL_LIM; j++) begin
			if (j < PL_LIM && scpf_pkg::COUNT_W'(j) < cnt) begin
				row[scpf_pkg::FIXED_BYTES + j] = '{vld: 1'b1, lst: 1'b0, data: pl_byte[j]};
			end else if (scpf_pkg::COUNT_W'(j) == cnt) begin
				row[scpf_pkg::FIXED_BYTES + j] = '{vld: 1'b1, lst: 1'b1, data: csum};
			end
		end
	end

endmodule

/* hw/rtl/scpf_cell.sv */
// One slot of the output shift row: parallel load, shift towards the port.
module scpf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            shift,
	input  scpf_pkg::slot_t load_val,
	input  scpf_pkg::slot_t nxt,
	output scpf_pkg::slot_t cur
);

	logic                        vld_q;
	logic                        lst_q;
	logic [scpf_pkg::BYTE_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= load_val.vld;
		end else if (shift) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lst_q  <= load_val.lst;
			data_q <= load_val.data;
		end else if (shift) begin
			lst_q  <= nxt.lst;
			data_q <= nxt.data;
		end
	end

	assign cur = '{vld: vld_q, lst: lst_q, data: data_q};

endmodule

/* hw/rtl/scpf_checker.sv */
// Port-level checks for the framer, bound to the top level.
module scpf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       pkt_valid,
	input logic       pkt_ready,
	input logic [7:0] pkt_byte,
	input logic       pkt_last
);

	// a taken command shows its first header byte next cycle
	a_first_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> pkt_valid && pkt_byte == scpf_pkg::HDR_FIRST)
		else $error("first header byte missing after command");

	// no command taken while a byte is stuck at the port
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready && pkt_valid |-> pkt_ready)
		else $error("command taken over a stalled byte");

	// after the end of a packet, only a new header may follow
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_ready && pkt_last |=>
		!pkt_valid || pkt_byte == scpf_pkg::HDR_FIRST)
		else $error("stray byte after end of packet");

	// stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_byte) && $stable(pkt_last))
		else $error("stalled byte changed");

endmodule

bind servo_command_packet_framer_unit scpf_checker u_scpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.pkt_valid (pkt.valid),
	.pkt_ready (pkt.ready),
	.pkt_byte  (pkt.packet_byte),
	.pkt_last  (pkt.last_byte)
);

/* tb/scpf_packet_checker.sv */
// Packet checker: predicts each packet from its command beat and compares the byte stream.
module scpf_packet_checker #(
	parameter int MAX_PAYLOAD_BYTES = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	scpf_cmd_if   cmd,
	scpf_byte_if  pkt,
	output int    fail_count,
	output int    pending
);
	import scpf_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} packet_beat_t;

	packet_beat_t expected_bytes[$];
	int           mismatches = 0;

	// header, fixed fields, clamped payload, XOR from id onwards
	function automatic void frame_command(
		input logic [BYTE_W-1:0]    id,
		input logic [BYTE_W-1:0]    fl,
		input logic [BYTE_W-1:0]    ad,
		input logic [BYTE_W-1:0]    ln,
		input logic [BYTE_W-1:0]    ct,
		input logic [PAYLOAD_W-1:0] pl,
		input logic [COUNT_W-1:0]   nb
	);
		logic [BYTE_W-1:0] head [FIXED_BYTES];
		logic [BYTE_W-1:0] xsum;
		logic [BYTE_W-1:0] b;
		int                limit;
		int                n;
		head[0] = HDR_FIRST;
		head[1] = HDR_SECOND;
		head[2] = id;
		head[3] = fl;
		head[4] = ad;
		head[5] = ln;
		head[6] = ct;
		limit = (MAX_PAYLOAD_BYTES < PAYLOAD_FIELD_BYTES) ? MAX_PAYLOAD_BYTES
			: PAYLOAD_FIELD_BYTES;
		n = (int'(nb) > limit) ? limit : int'(nb);
		xsum = '0;
		for (int i = 0; i < FIXED_BYTES; i++) begin
			if (i >= 2)
				xsum ^= head[i];
			expected_bytes.push_back('{value: head[i], last: 1'b0});
		end
		for (int i = 0; i < n; i++) begin
			b = pl[BYTE_W*i +: BYTE_W];
			xsum ^= b;
			expected_bytes.push_back('{value: b, last: 1'b0});
		end
		expected_bytes.push_back('{value: xsum, last: 1'b1});
	endfunction

	always @(posedge clk) begin
		packet_beat_t want;
		if (arst_n) begin
			// output side first; a packet's first byte never shares an edge with its command
			if (pkt.valid && pkt.ready) begin
				if (expected_bytes.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected byte %02h last %b at %0t",
							pkt.packet_byte, pkt.last_byte, $realtime);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (pkt.packet_byte !== want.value || pkt.last_byte !== want.last) begin
						if (mismatches < 10)
							$display("byte mismatch at %0t: expected %02h last %b, got %02h last %b",
								$realtime, want.value, want.last, pkt.packet_byte,
								pkt.last_byte);
						mismatches++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				frame_command(cmd.servo_id, cmd.flags, cmd.address, cmd.item_length,
					cmd.item_count, cmd.payload, cmd.payload_bytes);
			fail_count <= mismatches;
			pending    <= expected_bytes.size();
		end
	end

endmodule

/* tb/tb_servo_command_packet_framer_unit.sv */
// Testbench top for the servo command packet framer: stimulus, back-pressure and verdict.
module tb_servo_command_packet_framer_unit;
	import scpf_pkg::*;

	localparam int MAX_PL         = 4;
	localparam int WATCHDOG_LIMIT = 2000;   // cycles without any beat
	localparam int TAIL_CYCLES    = 24;     // quiet tail after the last expected byte

	typedef struct packed {
		logic [BYTE_W-1:0]    servo_id;
		logic [BYTE_W-1:0]    flags;
		logic [BYTE_W-1:0]    address;
		logic [BYTE_W-1:0]    item_length;
		logic [BYTE_W-1:0]    item_count;
		logic [PAYLOAD_W-1:0] payload;
		logic [COUNT_W-1:0]   payload_bytes;
	} command_t;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   quiet_cycles = 0;
	int   fail_count;
	int   pending;

	scpf_cmd_if  cmd();
	scpf_byte_if pkt();

	servo_command_packet_framer_unit #(
		.MAX_PAYLOAD_BYTES(MAX_PL)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pkt    (pkt)
	);

	scpf_packet_checker #(
		.MAX_PAYLOAD_BYTES(MAX_PL)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.pkt        (pkt),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 2-unit clock; stimulus moves on the falling edge, everything samples on the rising one
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sink back-pressure: ready redrawn every cycle, so stalls land on any byte of a packet,
	// including the checksum beat and the beat that lets the next command in.
	always @(negedge clk) begin
		pkt.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a run that stops moving beats on either channel is a hang.
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (pkt.valid && pkt.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Mostly random bytes, with the all-zero and all-one extremes turning up often.
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	function automatic command_t random_command();
		command_t c;
		c.servo_id    = pick_byte();
		c.flags       = pick_byte();
		c.address     = pick_byte();
		c.item_length = pick_byte();
		c.item_count  = pick_byte();
		c.payload     = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		// a quarter of the time the full 3-bit range, so the clamp gets regular exercise
		if ($urandom_range(3) == 0)
			c.payload_bytes = COUNT_W'($urandom_range(7));
		else
			c.payload_bytes = COUNT_W'($urandom_range(4));
		return c;
	endfunction

	// Called at a falling edge; returns at the falling edge after the command beat.
	task automatic send_command(input command_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.servo_id      <= c.servo_id;
		cmd.flags         <= c.flags;
		cmd.address       <= c.address;
		cmd.item_length   <= c.item_length;
		cmd.item_count    <= c.item_count;
		cmd.payload       <= c.payload;
		cmd.payload_bytes <= c.payload_bytes;
		do
			@(posedge clk);
		while (!cmd.ready);
		@(negedge clk);
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.servo_id      = '0;
		cmd.flags         = '0;
		cmd.address       = '0;
		cmd.item_length   = '0;
		cmd.item_count    = '0;
		cmd.payload       = '0;
		cmd.payload_bytes = '0;
		pkt.ready         = 1'b0;
		send_idle_pct     = 14;
		recv_idle_pct     = 77;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, every payload length, clamping, checksum corner cases.
		// No payload: checksum straight after the count byte.
		send_command('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 3'd0});
		send_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'd0});
		// Full payload, all ones; XOR of nine 0xFF bytes
		send_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'd4});
		// each payload length, distinct bytes so the byte order shows
		send_command('{8'h01, 8'h00, 8'h1E, 8'h01, 8'h01, 32'h4433_2211, 3'd1});
		send_command('{8'h02, 8'h00, 8'h24, 8'h02, 8'h01, 32'h4433_2211, 3'd2});
		send_command('{8'h03, 8'h00, 8'h1E, 8'h03, 8'h01, 32'h4433_2211, 3'd3});
		send_command('{8'h04, 8'h00, 8'h24, 8'h04, 8'h01, 32'h4433_2211, 3'd4});
		// counts above four saturate; bytes beyond the field must not appear
		send_command('{8'h05, 8'h20, 8'h1E, 8'h02, 8'h01, 32'hDEAD_BEEF, 3'd5});
		send_command('{8'h06, 8'h40, 8'h24, 8'h02, 8'h01, 32'hCAFE_F00D, 3'd6});
		send_command('{8'h07, 8'h20, 8'h1E, 8'h04, 8'h01, 32'h8000_0001, 3'd7});
		// broadcast id with reboot-style flags, nothing after
		send_command('{8'hFF, 8'h20, 8'hFF, 8'h00, 8'h00, 32'h0000_0000, 3'd0});
		// header bytes echoed in the fields and payload
		send_command('{8'hFA, 8'hAF, 8'hFA, 8'hAF, 8'hFA, 32'hAFFA_AFFA, 3'd4});
		// alternating bit patterns; the first checksum cancels to zero
		send_command('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'h00, 32'h0000_0000, 3'd0});
		send_command('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'hFF, 32'h55AA_55AA, 3'd4});
		// checksum of 0xFF in one payload byte only
		send_command('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_00FF, 3'd1});
		send_command('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFF00_0000, 3'd4});
		// top payload byte present in the field but cut off by a count of three
		send_command('{8'h12, 8'h40, 8'h30, 8'h01, 8'h03, 32'hFF12_3456, 3'd3});

		// Random, in three back-pressure regimes: slow sink, slow source, then flat out.
		for (int k = 0; k < 34; k++)
			send_command(random_command());
		send_idle_pct = 77;
		recv_idle_pct = 14;
		for (int k = 0; k < 33; k++)
			send_command(random_command());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int k = 0; k < 33; k++)
			send_command(random_command());

		cmd.valid <= 1'b0;

		// drain, then give the block time to show any stray byte
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
